FILE: sv/rbfb_pkg.sv
// Shared types and constants for the batch-pop ring buffer FIFO.
// Used by rbfb_front, rbfb_back, rbfb_outq and the top level.
`default_nettype none

package rbfb_pkg;

    // Parameter defaults
    localparam int CELLS_DEF  = 64;
    localparam int DATA_W_DEF = 64;

    // Fixed field widths of the channels
    localparam int FIELD_DATA_W = 64;
    localparam int LEN_W        = 6;
    localparam int CNT_W        = 6;

    // Operation codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // One accepted command as it waits for the executor
    typedef struct packed {
        logic                    func;
        logic [FIELD_DATA_W-1:0] data;
        logic [CNT_W-1:0]        count;
    } t_cmd;

    // One result beat
    typedef struct packed {
        logic                    push_accepted;
        logic                    item_valid;
        logic [FIELD_DATA_W-1:0] item_data;
        logic                    last;
        logic [LEN_W-1:0]        length_now;
        logic                    is_empty;
    } t_res;

endpackage

`default_nettype wire

FILE: sv/rbfb_front.sv
// Front end: accepts input beats and holds them in a two-entry command queue.
// Depends on rbfb_pkg for the command type.
`default_nettype none

module rbfb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire rbfb_pkg::t_cmd i_cmd,
    output logic               o_cmd_valid,
    output rbfb_pkg::t_cmd     o_cmd,
    input  wire logic          i_cmd_take
);
    import rbfb_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_put;

    // Stall only when both entries are taken
    assign o_stall     = (r_cnt == 2'd2);
    assign w_put       = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // Store accepted beats, normalizing the unused fields of each operation
    always_ff @(posedge i_clk) begin
        if (w_put) begin
            r_q[r_wp].func  <= i_cmd.func;
            r_q[r_wp].data  <= (i_cmd.func == FUNC_PUSH) ? i_cmd.data : '0;
            r_q[r_wp].count <= (i_cmd.func == FUNC_POP) ? i_cmd.count : '0;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_put) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= 2'(r_cnt + 2'(w_put) - 2'(i_cmd_take));
        end
    end

endmodule

`default_nettype wire

FILE: sv/rbfb_outq.sv
// Output queue: two result entries that decouple the executor from the sink.
// Depends on rbfb_pkg for the result type.
`default_nettype none

module rbfb_outq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire rbfb_pkg::t_res i_res,
    output logic                o_valid,
    input  wire logic           i_stall,
    output rbfb_pkg::t_res      o_res,
    output logic [1:0]          o_cnt,
    output logic                o_pop
);
    import rbfb_pkg::*;

    t_res       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_res   = r_q[r_rp];
    assign o_cnt   = r_cnt;
    assign o_pop   = o_valid && !i_stall;

    // Capture result beats
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_res;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (o_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= 2'(r_cnt + 2'(i_push) - 2'(o_pop));
        end
    end

endmodule

`default_nettype wire

FILE: sv/rbfb_back.sv
// Back end: executes push and pop commands on the cell memory and pointers.
// Depends on rbfb_pkg; feeds rbfb_outq one result beat per cycle at most.
`default_nettype none

module rbfb_back #(
    parameter int CELLS      = rbfb_pkg::CELLS_DEF,
    parameter int DATA_WIDTH = rbfb_pkg::DATA_W_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_valid,
    input  wire rbfb_pkg::t_cmd i_cmd,
    output logic                o_cmd_take,
    input  wire logic [1:0]     i_outq_cnt,
    input  wire logic           i_out_pop,
    output logic                o_res_valid,
    output rbfb_pkg::t_res      o_res
);
    import rbfb_pkg::*;

    localparam int PTR_W = $clog2(CELLS);
    localparam logic [PTR_W-1:0] FULL_LEN = PTR_W'(CELLS - 1);

    logic [DATA_WIDTH-1:0] r_mem [CELLS];
    logic [DATA_WIDTH-1:0] r_rdata;

    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [PTR_W-1:0] w_len, w_len_after;
    logic             r_active, n_active;
    logic [CNT_W-1:0] r_left, n_left, w_eff_left;
    logic             r_inf_valid, n_inf_valid;
    t_res             r_inf, n_inf;
    logic [2:0]       w_occ;
    logic             w_issue_ok;
    logic             w_push_do;

    // Keep outq plus the in-flight beat within the queue depth
    assign w_occ      = 3'(i_outq_cnt) + 3'(r_inf_valid) - 3'(i_out_pop);
    assign w_issue_ok = (w_occ < 3'd2);

    assign w_len      = PTR_W'(r_wr - r_rd);
    assign w_eff_left = r_active ? r_left : i_cmd.count;

    // Issue one step of the head command
    always_comb begin
        n_wr        = r_wr;
        n_rd        = r_rd;
        n_active    = r_active;
        n_left      = r_left;
        n_inf_valid = 1'b0;
        n_inf       = '0;
        o_cmd_take  = 1'b0;
        w_push_do   = 1'b0;
        if (i_cmd_valid && w_issue_ok) begin
            n_inf_valid = 1'b1;
            n_inf.last  = 1'b1;
            if (!r_active && i_cmd.func == FUNC_PUSH) begin
                o_cmd_take = 1'b1;
                if (w_len != FULL_LEN) begin
                    w_push_do           = 1'b1;
                    n_wr                = PTR_W'(r_wr + 1'b1);
                    n_inf.push_accepted = 1'b1;
                end
            end else if (!r_active && (w_len == '0 || i_cmd.count == '0)) begin
                // Empty queue or zero count: one empty result
                o_cmd_take = 1'b1;
            end else begin
                n_inf.item_valid = 1'b1;
                n_rd             = PTR_W'(r_rd + 1'b1);
                n_left           = CNT_W'(w_eff_left - 1'b1);
                n_inf.last       = (w_eff_left == CNT_W'(1)) || (w_len == PTR_W'(1));
                if (n_inf.last) begin
                    o_cmd_take = 1'b1;
                    n_active   = 1'b0;
                end else begin
                    n_active   = 1'b1;
                end
            end
        end
        w_len_after      = PTR_W'(n_wr - n_rd);
        n_inf.length_now = LEN_W'(w_len_after);
        n_inf.is_empty   = (w_len_after == '0);
    end

    // Cell memory: one write port, registered read at the read pointer
    always_ff @(posedge i_clk) begin
        if (w_push_do) begin
            r_mem[r_wr] <= i_cmd.data[DATA_WIDTH-1:0];
        end
        r_rdata <= r_mem[r_rd];
    end

    // Hold in-flight beat metadata
    always_ff @(posedge i_clk) begin
        r_inf <= n_inf;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_active    <= 1'b0;
            r_left      <= '0;
            r_inf_valid <= 1'b0;
        end else begin
            r_wr        <= n_wr;
            r_rd        <= n_rd;
            r_active    <= n_active;
            r_left      <= n_left;
            r_inf_valid <= n_inf_valid;
        end
    end

    // Merge read data into the beat
    always_comb begin
        o_res           = r_inf;
        o_res.item_data = r_inf.item_valid ? FIELD_DATA_W'(r_rdata) : '0;
    end
    assign o_res_valid = r_inf_valid;

endmodule

`default_nettype wire

FILE: sv/ring_buffer_fifo_batch_pop_top.sv
// Top level of the batch-pop ring buffer FIFO: front queue, executor, output queue.
// Depends on rbfb_pkg, rbfb_front, rbfb_back and rbfb_outq.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------------
//  input   | in        | i_valid / o_stall   | i_func, i_push_data, i_pop_count
//  output  | out       | o_valid / i_stall   | o_push_accepted, o_item_valid, o_item_data,
//          |           |                     | o_last, o_length_now, o_is_empty
//
// A push is one executor step; a pop returns min(count, length) words, one per
// step, and a single empty result when that is zero. The executor issues one
// memory read per cycle while the output queue has room, and its registered read
// data reaches the output queue in the following cycle. A result beat passes
// through the command queue, the in-flight register and the output queue.
// Reset clears pointers and queues; the cell memory needs no clearing.
// Output stall backs up into the two-entry output queue, then the executor,
// then the two-entry command queue, which raises o_stall when full.
`default_nettype none

module ring_buffer_fifo_batch_pop_top #(
    parameter int CELLS      = rbfb_pkg::CELLS_DEF,
    parameter int DATA_WIDTH = rbfb_pkg::DATA_W_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_func,
    input  wire logic [63:0] i_push_data,
    input  wire logic [5:0]  i_pop_count,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_push_accepted,
    output logic             o_item_valid,
    output logic [63:0]      o_item_data,
    output logic             o_last,
    output logic [5:0]       o_length_now,
    output logic             o_is_empty
);
    import rbfb_pkg::*;

    t_cmd       w_in_cmd, w_cmd;
    logic       w_cmd_valid, w_cmd_take;
    t_res       w_res, w_out_res;
    logic       w_res_valid;
    logic [1:0] w_outq_cnt;
    logic       w_out_pop;

    assign w_in_cmd.func  = i_func;
    assign w_in_cmd.data  = i_push_data;
    assign w_in_cmd.count = i_pop_count;

    rbfb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (w_in_cmd),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_take  (w_cmd_take)
    );

    rbfb_back #(
        .CELLS      (CELLS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_take  (w_cmd_take),
        .i_outq_cnt  (w_outq_cnt),
        .i_out_pop   (w_out_pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    rbfb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (w_out_res),
        .o_cnt   (w_outq_cnt),
        .o_pop   (w_out_pop)
    );

    // Split the result beat onto the ports
    assign o_push_accepted = w_out_res.push_accepted;
    assign o_item_valid    = w_out_res.item_valid;
    assign o_item_data     = w_out_res.item_data;
    assign o_last          = w_out_res.last;
    assign o_length_now    = w_out_res.length_now;
    assign o_is_empty      = w_out_res.is_empty;

endmodule

`default_nettype wire

FILE: sv/rbfb_checker.sv
// Port-level checker for ring_buffer_fifo_batch_pop_top, with its bind.
// Depends only on the top level's ports.
`default_nettype none

module rbfb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_push_accepted,
    input wire logic        o_item_valid,
    input wire logic [63:0] o_item_data,
    input wire logic        o_last,
    input wire logic [5:0]  o_length_now,
    input wire logic        o_is_empty
);

    // Stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item_data) && $stable(o_last))
        else $error("stalled output beat changed");

    // Empty flag agrees with the length
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_is_empty == (o_length_now == 6'd0)))
        else $error("empty flag disagrees with length");

    // Accepted push results carry no word and end the item
    a_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_push_accepted |-> !o_item_valid && o_last)
        else $error("push result malformed");

    // Beats without a word are single, zero and last
    a_noword: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item_valid |-> o_last && (o_item_data == 64'd0))
        else $error("wordless result malformed");

    // A popped word lowers the length, so a beat with a word never reports a full queue
    a_popfull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item_valid |-> (o_length_now != 6'd63))
        else $error("popped word reports full queue");

endmodule

bind ring_buffer_fifo_batch_pop_top rbfb_checker u_rbfb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_push_accepted (o_push_accepted),
    .o_item_valid    (o_item_valid),
    .o_item_data     (o_item_data),
    .o_last          (o_last),
    .o_length_now    (o_length_now),
    .o_is_empty      (o_is_empty)
);

`default_nettype wire
